// ===== rtl/dimh_pkg.sv =====
// Shared constants for the decay invariant mass block: codes, register map, field widths.
package dimh_pkg;

  localparam int MASS_W   = 20;
  localparam int OUT_W    = 28;
  localparam int MODE_W   = 2;
  localparam int CHARGE_W = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // track slots, also the mode codes of the input word
  localparam logic [MODE_W-1:0] MODE_KAON     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_JPSI     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PION_ONE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PION_TWO = 2'd3;

  localparam logic [CHARGE_W-1:0] CHG_NEG   = 2'd0;
  localparam logic [CHARGE_W-1:0] CHG_POS   = 2'd1;
  localparam logic [CHARGE_W-1:0] CHG_UNDEF = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PION_MASS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KAON_MASS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JPSI_MASS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 3'd4;

  localparam logic [MASS_W-1:0] PION_MASS_RST   = 20'd2233;
  localparam logic [MASS_W-1:0] KAON_MASS_RST   = 20'd7899;
  localparam logic [MASS_W-1:0] JPSI_MASS_RST   = 20'd49550;
  localparam logic [MASS_W-1:0] WINDOW_LOW_RST  = 20'd83232;
  localparam logic [MASS_W-1:0] WINDOW_HIGH_RST = 20'd84000;

endpackage

// ===== rtl/decay_invariant_mass_hypotheses.sv =====
// Top level: four-track invariant mass hypotheses on one shared add/subtract unit.
//
// Input channel (in_valid/in_ready): one word per track; mode selects the slot
// (kaon, J/psi, pion one, pion two). Kaon, J/psi and pion-one words are stored
// and taken while the sequencer stays idle. A pion-two word closes the
// candidate and starts the sequencer; in_ready stays low until the result is
// handed to the output register.
// Output channel (out_valid/out_ready): one word per pion-two word with the
// four-track mass (kaon as pion), the J/psi-kaon-pion mass and the window flag.
// A candidate mass inside the window adds a second pass. Every square runs
// shift-and-add through the one adder, one multiplier bit a cycle, and stops
// when the remaining multiplier bits are zero; every square root yields one
// root bit a cycle on the same adder. Small momenta therefore finish sooner.
// Reset sets the mass and window registers to their defaults, marks both
// stored charges unidentified and empties the output register. Stored momenta
// hold garbage until written. A stalled receiver holds the output word; a
// finished word then waits behind it and in_ready stays low until it moves up.
module decay_invariant_mass_hypotheses
  import dimh_pkg::*;
#(
  parameter int MOM_WIDTH = 28
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [MASS_W-1:0]           cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [MODE_W-1:0]           in_mode,
  input  logic signed [MOM_WIDTH-1:0] in_mom_x,
  input  logic signed [MOM_WIDTH-1:0] in_mom_y,
  input  logic signed [MOM_WIDTH-1:0] in_mom_z,
  input  logic [CHARGE_W-1:0]         in_charge_code,
  input  logic [MASS_W-1:0]           in_candidate_mass,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [OUT_W-1:0]            out_mass_kaon_as_pion,
  output logic [OUT_W-1:0]            out_mass_jpsi_kaon_pion,
  output logic                        out_in_window
);

  localparam int MW   = MOM_WIDTH;
  localparam int EW   = ((MW > 21) ? MW : 21) + 3;  // energies and roots
  localparam int SW   = 2 * EW;                     // radicands
  localparam int AW   = SW + 2;                     // accumulator, signed
  localparam int SUMW = MW + 2;                     // summed momentum
  localparam int CW   = $clog2(EW);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_SQRT_INIT, S_SQRT, S_ROUND, S_ACCUM, S_FIN
  } state_t;
  localparam state_t S_OUT_UNUSED = S_IDLE;

  typedef enum logic {S_WAIT_OUT_NO, S_WAIT_OUT_YES} out_wait_t;

  state_t state_r, state_nxt;
  out_wait_t hold_r, hold_nxt;

  logic [MASS_W-1:0] pion_mass_r, kaon_mass_r, jpsi_mass_r, win_low_r, win_high_r;
  logic [CHARGE_W-1:0] kaon_chg_r, kaon_chg_nxt, pion1_chg_r, pion1_chg_nxt;

  logic signed [MW-1:0] trk_x_r [4];
  logic signed [MW-1:0] trk_y_r [4];
  logic signed [MW-1:0] trk_z_r [4];

  logic pass_r, pass_nxt, mph_r, mph_nxt, win_r, win_nxt;
  logic [1:0] cnt_r, cnt_nxt, sq_r, sq_nxt;
  logic [AW-1:0] acc_r, acc_nxt, md_r, md_nxt;
  logic [EW-1:0] mq_r, mq_nxt, root_r, root_nxt, se_r, se_nxt;
  logic [SW-1:0] rad_r, rad_nxt;
  logic [CW-1:0] scnt_r, scnt_nxt;
  logic signed [SUMW-1:0] sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic [OUT_W-1:0] m1_r, m1_nxt, m2_r, m2_nxt;
  logic out_valid_r, out_valid_nxt, out_win_r, out_win_nxt;
  logic [OUT_W-1:0] out_m1_r, out_m1_nxt, out_m2_r, out_m2_nxt;

  logic in_accept;
  logic [MODE_W-1:0] cur_slot, pion_sel;
  logic has_pion, last_trk;
  logic [MASS_W-1:0] cur_mass;
  logic signed [MW-1:0] trk_c;
  logic signed [SUMW-1:0] sum_c;
  logic [MW-1:0] trk_mag;
  logic [SUMW-1:0] sum_mag;
  logic [EW-1:0] opnd;
  logic [AW-1:0] alu_a, alu_b, alu_sum, remx, trial;
  logic alu_sub, sat;
  logic [OUT_W-1:0] mass_val;

  assign in_ready  = (state_r == S_IDLE) && (hold_r == S_WAIT_OUT_NO);
  assign in_accept = in_valid && in_ready;

  assign out_valid               = out_valid_r;
  assign out_mass_kaon_as_pion   = out_m1_r;
  assign out_mass_jpsi_kaon_pion = out_m2_r;
  assign out_in_window           = out_win_r;

  // pion paired with the kaon: pion one if its charge is opposite, else pion two
  always_comb begin
    has_pion = (kaon_chg_r == CHG_POS) || (kaon_chg_r == CHG_NEG);
    if (kaon_chg_r == CHG_POS) begin
      pion_sel = (pion1_chg_r == CHG_NEG) ? MODE_PION_ONE : MODE_PION_TWO;
    end else begin
      pion_sel = (pion1_chg_r == CHG_POS) ? MODE_PION_ONE : MODE_PION_TWO;
    end
  end

  always_comb begin
    case (cnt_r)
      2'd0:    cur_slot = MODE_JPSI;
      2'd1:    cur_slot = MODE_KAON;
      2'd2:    cur_slot = pass_r ? pion_sel : MODE_PION_ONE;
      default: cur_slot = MODE_PION_TWO;
    endcase
    if (pass_r) begin
      last_trk = (cnt_r == (has_pion ? 2'd2 : 2'd1));
    end else begin
      last_trk = (cnt_r == 2'd3);
    end
    if (cur_slot == MODE_JPSI) begin
      cur_mass = jpsi_mass_r;
    end else if (cur_slot == MODE_KAON && pass_r) begin
      cur_mass = kaon_mass_r;
    end else begin
      cur_mass = pion_mass_r;
    end
  end

  // operand of the next square
  always_comb begin
    case (sq_r)
      2'd1: begin
        trk_c = trk_x_r[cur_slot];
        sum_c = sx_r;
      end
      2'd2: begin
        trk_c = trk_y_r[cur_slot];
        sum_c = sy_r;
      end
      default: begin
        trk_c = trk_z_r[cur_slot];
        sum_c = sz_r;
      end
    endcase
    trk_mag = trk_c[MW-1] ? MW'(-trk_c) : MW'(trk_c);
    sum_mag = sum_c[SUMW-1] ? SUMW'(-sum_c) : SUMW'(sum_c);
    if (sq_r == 2'd0) begin
      opnd = mph_r ? se_r : EW'(cur_mass);
    end else begin
      opnd = mph_r ? EW'(sum_mag) : EW'(trk_mag);
    end
  end

  assign remx  = {acc_r[SW-1:0], rad_r[SW-1:SW-2]};
  assign trial = AW'({root_r, 2'b01});
  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

  always_comb begin
    sat      = (EW > OUT_W) && ((root_r >> OUT_W) != '0);
    mass_val = sat ? OUT_MAX : OUT_W'(root_r);
  end

  always_comb begin
    state_nxt     = state_r;
    hold_nxt      = hold_r;
    kaon_chg_nxt  = kaon_chg_r;
    pion1_chg_nxt = pion1_chg_r;
    pass_nxt      = pass_r;
    mph_nxt       = mph_r;
    win_nxt       = win_r;
    cnt_nxt       = cnt_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    md_nxt        = md_r;
    mq_nxt        = mq_r;
    root_nxt      = root_r;
    se_nxt        = se_r;
    rad_nxt       = rad_r;
    scnt_nxt      = scnt_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sz_nxt        = sz_r;
    m1_nxt        = m1_r;
    m2_nxt        = m2_r;
    out_valid_nxt = out_valid_r;
    out_win_nxt   = out_win_r;
    out_m1_nxt    = out_m1_r;
    out_m2_nxt    = out_m2_r;
    alu_a         = acc_r;
    alu_b         = md_r;
    alu_sub       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    // hand a finished word to the output register once it is free
    if (hold_r == S_WAIT_OUT_YES && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_m1_nxt    = m1_r;
      out_m2_nxt    = m2_r;
      out_win_nxt   = win_r;
      hold_nxt      = S_WAIT_OUT_NO;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_mode == MODE_KAON) begin
            kaon_chg_nxt = in_charge_code;
          end
          if (in_mode == MODE_PION_ONE) begin
            pion1_chg_nxt = in_charge_code;
          end
          if (in_mode == MODE_PION_TWO) begin
            pass_nxt  = 1'b0;
            mph_nxt   = 1'b0;
            cnt_nxt   = '0;
            sq_nxt    = '0;
            acc_nxt   = '0;
            se_nxt    = '0;
            sx_nxt    = '0;
            sy_nxt    = '0;
            sz_nxt    = '0;
            win_nxt   = (in_candidate_mass > win_low_r) && (in_candidate_mass < win_high_r);
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        md_nxt    = AW'(opnd);
        mq_nxt    = opnd;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        alu_sub = mph_r && (sq_r != 2'd0);
        if (mq_r == '0) begin
          if (sq_r == 2'd3) begin
            if (mph_r && (acc_r[AW-1] || acc_r == '0)) begin
              // mass squared not positive: clamp to zero
              root_nxt  = '0;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_SQRT_INIT;
            end
          end else begin
            sq_nxt    = sq_r + 2'd1;
            state_nxt = S_LOAD;
          end
        end else begin
          if (mq_r[0]) begin
            acc_nxt = alu_sum;
          end
          md_nxt = {md_r[AW-2:0], 1'b0};
          mq_nxt = {1'b0, mq_r[EW-1:1]};
        end
      end
      S_SQRT_INIT: begin
        rad_nxt   = acc_r[SW-1:0];
        acc_nxt   = '0;
        root_nxt  = '0;
        scnt_nxt  = CW'(EW - 1);
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        alu_a   = remx;
        alu_b   = trial;
        alu_sub = 1'b1;
        if (!alu_sum[AW-1]) begin
          acc_nxt  = alu_sum;
          root_nxt = {root_r[EW-2:0], 1'b1};
        end else begin
          acc_nxt  = remx;
          root_nxt = {root_r[EW-2:0], 1'b0};
        end
        rad_nxt = {rad_r[SW-3:0], 2'b00};
        if (scnt_r == '0) begin
          state_nxt = S_ROUND;
        end else begin
          scnt_nxt = scnt_r - CW'(1);
        end
      end
      S_ROUND: begin
        // round up when the remainder exceeds the root
        alu_a   = AW'(root_r);
        alu_b   = acc_r;
        alu_sub = 1'b1;
        if (alu_sum[AW-1]) begin
          root_nxt = root_r + EW'(1);
        end
        state_nxt = mph_r ? S_FIN : S_ACCUM;
      end
      S_ACCUM: begin
        se_nxt  = se_r + root_r;
        sx_nxt  = sx_r + SUMW'(trk_x_r[cur_slot]);
        sy_nxt  = sy_r + SUMW'(trk_y_r[cur_slot]);
        sz_nxt  = sz_r + SUMW'(trk_z_r[cur_slot]);
        acc_nxt = '0;
        sq_nxt  = '0;
        if (last_trk) begin
          mph_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
        state_nxt = S_LOAD;
      end
      S_FIN: begin
        if (!pass_r) begin
          m1_nxt = mass_val;
          if (win_r) begin
            pass_nxt  = 1'b1;
            mph_nxt   = 1'b0;
            cnt_nxt   = '0;
            sq_nxt    = '0;
            acc_nxt   = '0;
            se_nxt    = '0;
            sx_nxt    = '0;
            sy_nxt    = '0;
            sz_nxt    = '0;
            state_nxt = S_LOAD;
          end else begin
            m2_nxt    = '0;
            hold_nxt  = S_WAIT_OUT_YES;
            state_nxt = S_OUT_UNUSED;
          end
        end else begin
          m2_nxt    = mass_val;
          hold_nxt  = S_WAIT_OUT_YES;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // track slots, overwritten by every accepted word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      trk_x_r[in_mode] <= in_mom_x;
      trk_y_r[in_mode] <= in_mom_y;
      trk_z_r[in_mode] <= in_mom_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_r      <= S_WAIT_OUT_NO;
      out_valid_r <= 1'b0;
      kaon_chg_r  <= CHG_UNDEF;
      pion1_chg_r <= CHG_UNDEF;
      pion_mass_r <= PION_MASS_RST;
      kaon_mass_r <= KAON_MASS_RST;
      jpsi_mass_r <= JPSI_MASS_RST;
      win_low_r   <= WINDOW_LOW_RST;
      win_high_r  <= WINDOW_HIGH_RST;
    end else begin
      state_r     <= state_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
      kaon_chg_r  <= kaon_chg_nxt;
      pion1_chg_r <= pion1_chg_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_PION_MASS:   pion_mass_r <= cfg_wdata;
          REG_KAON_MASS:   kaon_mass_r <= cfg_wdata;
          REG_JPSI_MASS:   jpsi_mass_r <= cfg_wdata;
          REG_WINDOW_LOW:  win_low_r   <= cfg_wdata;
          REG_WINDOW_HIGH: win_high_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
    pass_r   <= pass_nxt;
    mph_r    <= mph_nxt;
    win_r    <= win_nxt;
    cnt_r    <= cnt_nxt;
    sq_r     <= sq_nxt;
    acc_r    <= acc_nxt;
    md_r     <= md_nxt;
    mq_r     <= mq_nxt;
    root_r   <= root_nxt;
    se_r     <= se_nxt;
    rad_r    <= rad_nxt;
    scnt_r   <= scnt_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    sz_r     <= sz_nxt;
    m1_r     <= m1_nxt;
    m2_r     <= m2_nxt;
    out_win_r <= out_win_nxt;
    out_m1_r <= out_m1_nxt;
    out_m2_r <= out_m2_nxt;
  end

  a_out_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_window |-> out_mass_jpsi_kaon_pion == '0)
    else $error("second mass nonzero outside window");

  a_short_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_mode != MODE_PION_TWO |=> state_r == S_IDLE)
    else $error("non-closing word started the sequencer");

  a_rem_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT |-> !acc_r[AW-1])
    else $error("negative square root remainder");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("input taken while busy");

endmodule

// ===== dv/decay_invariant_mass_hypotheses_tb.sv =====
// Self-checking testbench for the four-track invariant mass hypotheses block.
`timescale 1ns / 1ps

module decay_invariant_mass_hypotheses_tb;
  import dimh_pkg::*;

  localparam int MOM_W = 28;
  localparam int IDLE_PCT = 21;
  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 1500;
  localparam logic [MASS_W-1:0] MASS_TOP = {MASS_W{1'b1}};
  localparam logic signed [MOM_W-1:0] MOM_MAX = {1'b0, {(MOM_W-1){1'b1}}};
  localparam logic signed [MOM_W-1:0] MOM_MIN = {1'b1, {(MOM_W-1){1'b0}}};
  // charge code with no meaning, acts as unidentified
  localparam logic [CHARGE_W-1:0] CHG_SPARE = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] mass_kaon_as_pion;
    logic [OUT_W-1:0] mass_jpsi_kaon_pion;
    logic             in_window;
  } mass_word_t;

  typedef struct {
    longint x, y, z;
    logic [63:0] e;
  } four_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASS_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] in_mode = '0;
  logic signed [MOM_W-1:0] in_mom_x = '0, in_mom_y = '0, in_mom_z = '0;
  logic [CHARGE_W-1:0] in_charge_code = '0;
  logic [MASS_W-1:0] in_candidate_mass = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_W-1:0] out_mass_kaon_as_pion, out_mass_jpsi_kaon_pion;
  logic out_in_window;

  decay_invariant_mass_hypotheses #(.MOM_WIDTH(MOM_W)) DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // shadow of the block's configuration and stored tracks
  logic [MASS_W-1:0] pion_m = PION_MASS_RST, kaon_m = KAON_MASS_RST, jpsi_m = JPSI_MASS_RST;
  logic [MASS_W-1:0] win_lo = WINDOW_LOW_RST, win_hi = WINDOW_HIGH_RST;
  longint slot_x[4], slot_y[4], slot_z[4];
  logic [CHARGE_W-1:0] kaon_chg = CHG_UNDEF, pion_one_chg = CHG_UNDEF;

  mass_word_t pending_masses[$];
  int mismatches = 0;
  int n_items = 0, n_results = 0, n_in_window = 0, n_saturated = 0;
  bit no_idle = 1'b0;
  bit failed = 1'b0;

  function automatic logic [63:0] sqrt_nearest(logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    if (v - r * r > r) r = r + 1;
    return r[63:0];
  endfunction

  function automatic logic [127:0] mom_sq(longint x, longint y, longint z);
    logic [127:0] ax, ay, az;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    return ax * ax + ay * ay + az * az;
  endfunction

  function automatic four_vec_t track_vec(logic [MODE_W-1:0] slot, logic [MASS_W-1:0] m);
    four_vec_t v;
    logic [127:0] m2;
    v.x = slot_x[slot];
    v.y = slot_y[slot];
    v.z = slot_z[slot];
    m2 = 128'(m) * 128'(m);
    v.e = sqrt_nearest(m2 + mom_sq(v.x, v.y, v.z));
    return v;
  endfunction

  function automatic four_vec_t vsum(four_vec_t a, four_vec_t b);
    four_vec_t r;
    r.x = a.x + b.x;
    r.y = a.y + b.y;
    r.z = a.z + b.z;
    r.e = a.e + b.e;
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] invariant_mass(four_vec_t v);
    logic [127:0] e2, p2;
    logic [63:0] m;
    e2 = 128'(v.e) * 128'(v.e);
    p2 = mom_sq(v.x, v.y, v.z);
    if (e2 <= p2) return '0;
    m = sqrt_nearest(e2 - p2);
    return (m > 64'(OUT_MAX)) ? OUT_MAX : m[OUT_W-1:0];
  endfunction

  // store the track and, on a pion-two word, queue the masses it yields
  task automatic predict_masses(logic [MODE_W-1:0] mode, logic signed [MOM_W-1:0] x,
                                logic signed [MOM_W-1:0] y, logic signed [MOM_W-1:0] z,
                                logic [CHARGE_W-1:0] chg, logic [MASS_W-1:0] cand);
    four_vec_t j, kp, p1, p2, s;
    mass_word_t w;
    slot_x[mode] = longint'(x);
    slot_y[mode] = longint'(y);
    slot_z[mode] = longint'(z);
    if (mode == MODE_KAON) kaon_chg = chg;
    if (mode == MODE_PION_ONE) pion_one_chg = chg;
    if (mode != MODE_PION_TWO) return;
    j = track_vec(MODE_JPSI, jpsi_m);
    kp = track_vec(MODE_KAON, pion_m);
    p1 = track_vec(MODE_PION_ONE, pion_m);
    p2 = track_vec(MODE_PION_TWO, pion_m);
    w.mass_kaon_as_pion = invariant_mass(vsum(vsum(j, kp), vsum(p1, p2)));
    w.in_window = (cand > win_lo) && (cand < win_hi);
    w.mass_jpsi_kaon_pion = '0;
    if (w.in_window) begin
      s = vsum(j, track_vec(MODE_KAON, kaon_m));
      if (kaon_chg == CHG_POS) s = vsum(s, (pion_one_chg == CHG_NEG) ? p1 : p2);
      else if (kaon_chg == CHG_NEG) s = vsum(s, (pion_one_chg == CHG_POS) ? p1 : p2);
      w.mass_jpsi_kaon_pion = invariant_mass(s);
    end
    pending_masses.push_back(w);
  endtask

  task automatic sender_gap();
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // send one track word; returns at the edge that accepts it, valid still high
  task automatic send_track(logic [MODE_W-1:0] mode, logic signed [MOM_W-1:0] x,
                            logic signed [MOM_W-1:0] y, logic signed [MOM_W-1:0] z,
                            logic [CHARGE_W-1:0] chg, logic [MASS_W-1:0] cand);
    sender_gap();
    in_valid <= 1'b1;
    in_mode <= mode;
    in_mom_x <= x;
    in_mom_y <= y;
    in_mom_z <= z;
    in_charge_code <= chg;
    in_candidate_mass <= cand;
    do @(posedge clk); while (!in_ready);
    predict_masses(mode, x, y, z, chg, cand);
    n_items++;
  endtask

  // hold the sender until every expected word is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_masses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // drive one register write; the caller drops cfg_we after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MASS_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_PION_MASS:   pion_m = val;
      REG_KAON_MASS:   kaon_m = val;
      REG_JPSI_MASS:   jpsi_m = val;
      REG_WINDOW_LOW:  win_lo = val;
      REG_WINDOW_HIGH: win_hi = val;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [MASS_W-1:0] pm, logic [MASS_W-1:0] km,
                             logic [MASS_W-1:0] jm, logic [MASS_W-1:0] lo,
                             logic [MASS_W-1:0] hi);
    drain();
    write_reg(REG_PION_MASS, pm);
    write_reg(REG_KAON_MASS, km);
    write_reg(REG_JPSI_MASS, jm);
    write_reg(REG_WINDOW_LOW, lo);
    write_reg(REG_WINDOW_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [MOM_W-1:0] rand_mom();
    logic [MOM_W-1:0] v;
    int w;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = MOM_MAX;
          1: v = MOM_MIN;
          2: v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3: v = MOM_W'($urandom);
      default: begin
        w = $urandom_range(1, MOM_W - 2);
        v = MOM_W'($urandom & ((32'd1 << w) - 1));
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [MASS_W-1:0] rand_cand();
    if ($urandom_range(1) && win_hi > win_lo + 1)
      return MASS_W'($urandom_range(win_hi - 1, win_lo + 1));
    case ($urandom_range(3))
      0: return win_lo;
      1: return win_hi;
      default: return MASS_W'($urandom);
    endcase
  endfunction

  task automatic test_directed_defaults();
    // a full candidate first, so no slot is ever read unwritten
    send_track(MODE_KAON, 28'sd16000, -28'sd3000, 28'sd40000, CHG_POS, '0);
    send_track(MODE_JPSI, -28'sd5000, 28'sd90000, 28'sd120000, CHG_UNDEF, '0);
    send_track(MODE_PION_ONE, 28'sd700, 28'sd2100, -28'sd9000, CHG_NEG, '0);
    send_track(MODE_PION_TWO, -28'sd1200, 28'sd800, 28'sd30000, CHG_POS, 20'd83500);
    // negative kaon pairs with pion one; candidate on the lower bound is outside
    send_track(MODE_KAON, 28'sd20000, 28'sd20000, -28'sd1000, CHG_NEG, '0);
    send_track(MODE_PION_ONE, 28'sd3000, -28'sd4000, 28'sd5000, CHG_POS, '0);
    send_track(MODE_PION_TWO, 28'sd100, 28'sd200, 28'sd300, CHG_NEG, WINDOW_LOW_RST);
    send_track(MODE_PION_TWO, 28'sd100, 28'sd200, 28'sd300, CHG_NEG, 20'd83233);
    // unidentified kaon and the meaningless charge code add no pion
    send_track(MODE_KAON, -28'sd8000, 28'sd1, 28'sd64000, CHG_UNDEF, '0);
    send_track(MODE_PION_TWO, 28'sd5, -28'sd7, 28'sd11, CHG_POS, 20'd83999);
    send_track(MODE_KAON, 28'sd8000, 28'sd1, -28'sd64000, CHG_SPARE, '0);
    send_track(MODE_PION_TWO, 28'sd5, -28'sd7, 28'sd11, CHG_NEG, 20'd83600);
    send_track(MODE_PION_TWO, 28'sd5, -28'sd7, 28'sd11, CHG_NEG, WINDOW_HIGH_RST);
    // same-sign pion one sends the positive kaon to pion two
    send_track(MODE_KAON, 28'sd9000, 28'sd9000, 28'sd9000, CHG_POS, '0);
    send_track(MODE_PION_ONE, -28'sd400, 28'sd400, 28'sd0, CHG_POS, '0);
    send_track(MODE_PION_TWO, 28'sd0, 28'sd0, 28'sd0, CHG_NEG, 20'd83800);
    // momentum extremes
    send_track(MODE_KAON, MOM_MAX, MOM_MAX, MOM_MAX, CHG_POS, '0);
    send_track(MODE_JPSI, MOM_MIN, MOM_MIN, MOM_MIN, CHG_NEG, '0);
    send_track(MODE_PION_ONE, MOM_MAX, MOM_MIN, '0, CHG_NEG, '0);
    send_track(MODE_PION_TWO, MOM_MIN, MOM_MAX, MOM_MAX, CHG_POS, MASS_TOP);
  endtask

  task automatic test_extreme_config();
    // zero masses and identical collinear tracks: rounded energies push mass squared below zero
    load_config('0, '0, '0, '0, MASS_TOP);
    send_track(MODE_KAON, 28'sd1, 28'sd1, 28'sd0, CHG_POS, '0);
    send_track(MODE_JPSI, 28'sd1, 28'sd1, 28'sd0, CHG_POS, '0);
    send_track(MODE_PION_ONE, 28'sd1, 28'sd1, 28'sd0, CHG_NEG, '0);
    send_track(MODE_PION_TWO, 28'sd1, 28'sd1, 28'sd0, CHG_POS, 20'd1);
    // heaviest masses with opposed extreme momenta saturate the output
    load_config(MASS_TOP, MASS_TOP, MASS_TOP, '0, MASS_TOP);
    send_track(MODE_KAON, MOM_MAX, MOM_MAX, MOM_MAX, CHG_NEG, '0);
    send_track(MODE_JPSI, MOM_MIN, MOM_MIN, MOM_MIN, CHG_UNDEF, '0);
    send_track(MODE_PION_ONE, MOM_MAX, MOM_MAX, MOM_MIN, CHG_POS, '0);
    send_track(MODE_PION_TWO, MOM_MIN, MOM_MIN, MOM_MAX, CHG_NEG, MASS_TOP - 20'd1);
    // empty window: low above high
    load_config(PION_MASS_RST, KAON_MASS_RST, JPSI_MASS_RST, MASS_TOP, '0);
    send_track(MODE_PION_TWO, 28'sd77, 28'sd0, -28'sd77, CHG_POS, 20'd5000);
  endtask

  task automatic test_random_candidates(int n_words);
    int sent;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 85) begin
        send_track(MODE_KAON, rand_mom(), rand_mom(), rand_mom(), CHARGE_W'($urandom), '0);
        send_track(MODE_JPSI, rand_mom(), rand_mom(), rand_mom(), CHARGE_W'($urandom),
                   MASS_W'($urandom));
        send_track(MODE_PION_ONE, rand_mom(), rand_mom(), rand_mom(), CHARGE_W'($urandom),
                   MASS_W'($urandom));
        send_track(MODE_PION_TWO, rand_mom(), rand_mom(), rand_mom(), CHARGE_W'($urandom),
                   rand_cand());
        sent += 4;
      end else begin
        // out-of-order or truncated sequence
        send_track(MODE_W'($urandom), rand_mom(), rand_mom(), rand_mom(),
                   CHARGE_W'($urandom), rand_cand());
        sent++;
      end
    end
  endtask

  task automatic mismatch(string what, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] act_v);
    mismatches++;
    failed = 1'b1;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
  endtask

  // receiver: random stalls except during the no-idle stretch
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    mass_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_masses.size() == 0) begin
        mismatches++;
        failed = 1'b1;
        if (mismatches <= 10) $display("unexpected result word");
      end else begin
        w = pending_masses.pop_front();
        n_results++;
        if (w.in_window) n_in_window++;
        if (w.mass_kaon_as_pion == OUT_MAX) n_saturated++;
        if (out_mass_kaon_as_pion !== w.mass_kaon_as_pion)
          mismatch("mass_kaon_as_pion", w.mass_kaon_as_pion, out_mass_kaon_as_pion);
        if (out_mass_jpsi_kaon_pion !== w.mass_jpsi_kaon_pion)
          mismatch("mass_jpsi_kaon_pion", w.mass_jpsi_kaon_pion, out_mass_jpsi_kaon_pion);
        if (out_in_window !== w.in_window)
          mismatch("in_window", OUT_W'(w.in_window), OUT_W'(out_in_window));
      end
    end
  end

  // watchdog: cycles in which no word moves on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_extreme_config();
    load_config(MASS_W'($urandom), MASS_W'($urandom), MASS_W'($urandom), 20'd40000,
                20'd300000);
    test_random_candidates(260);
    no_idle = 1'b1;
    load_config(MASS_W'($urandom), MASS_W'($urandom), MASS_W'($urandom),
                MASS_W'($urandom), MASS_W'($urandom));
    test_random_candidates(260);
    no_idle = 1'b0;
    load_config(MASS_TOP, '0, MASS_W'($urandom), '0, MASS_TOP);
    test_random_candidates(260);
    load_config(PION_MASS_RST, KAON_MASS_RST, JPSI_MASS_RST, WINDOW_LOW_RST,
                WINDOW_HIGH_RST);
    test_random_candidates(260);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d track words, checked %0d candidates (%0d in window, %0d saturated)",
             n_items, n_results, n_in_window, n_saturated);
    $display("covered five register settings, charge pairings and momentum extremes");
    if (!failed && pending_masses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d words still expected", mismatches, pending_masses.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dimh_pkg.sv
rtl/decay_invariant_mass_hypotheses.sv
dv/decay_invariant_mass_hypotheses_tb.sv
